// ===== hw/rtl/a85d_pkg.sv =====
// Shared types, character codes and constants of the ASCII85 decoder.
package a85d_pkg;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_BAD  = 2'd2
    } t_kind;

    localparam logic [7:0] CHAR_FIRST = 8'd33;
    localparam logic [7:0] CHAR_LAST  = 8'd117;
    localparam logic [7:0] CHAR_Z     = 8'h7a;
    localparam logic [7:0] CHAR_TILDE = 8'h7e;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;

    localparam logic [31:0] BASE       = 32'd85;
    localparam logic [2:0]  LAST_DIGIT = 3'd4;
    localparam logic [2:0]  WORD_BYTES = 3'd4;

    // Padding a group of k digits with 'u' gives (v + 1) * 85^(5-k) - 1.
    function automatic logic [19:0] pad_scale(input logic [2:0] count);
        logic [19:0] scale;
        case (count)
            3'd2:    scale = 20'd614125;
            3'd3:    scale = 20'd7225;
            3'd4:    scale = 20'd85;
            default: scale = 20'd1;
        endcase
        return scale;
    endfunction

endpackage

// ===== hw/rtl/a85d_in_if.sv =====
// Request channel carrying one encoded character per request.
interface a85d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] enc_byte;
    logic       end_of_input;
    logic       restart;

    modport source (output valid, output enc_byte, output end_of_input,
                    output restart, input ready);
    modport sink   (input valid, input enc_byte, input end_of_input,
                    input restart, output ready);
endinterface

// ===== hw/rtl/a85d_out_if.sv =====
// Result channel carrying one decoded byte or marker per request.
interface a85d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [1:0] result_kind;
    logic       last_of_run;

    modport source (output valid, output data_byte, output result_kind,
                    output last_of_run, input ready);
    modport sink   (input valid, input data_byte, input result_kind,
                    input last_of_run, output ready);
endinterface

// ===== hw/rtl/ascii85_decoder_top.sv =====
// Streaming ASCII85 decoder: input register, decode step, result run register.
//
//   channel | dir | payload                                  | handshake
//   i_in    | in  | enc_byte, end_of_input, restart          | valid/ready
//   o_res   | out | data_byte, result_kind, last_of_run      | valid/ready
//
// A request is registered in the input register, decoded into a run of up to four
// results in the run register, and the run drains one result per cycle while the
// sink is ready, through the single byte-wide result port; 'z' gives four results.
// A new request can enter the input register while a run drains. The input
// register holds one request while the run register waits on a stalled sink;
// input ready then drops until the run drains.
// Reset (synchronous, i_rst_n low) clears both valid flags, the result index, group value, digit count and ended.
module ascii85_decoder_top (
    input logic         i_clk,
    input logic         i_rst_n,
    a85d_in_if.sink     i_in,
    a85d_out_if.source  o_res
);

    typedef struct packed {
        logic [7:0] enc_byte;
        logic       end_of_input;
        logic       restart;
    } t_item;

    typedef struct packed {
        logic [31:0]     word;
        logic [2:0]      nbytes;
        logic            mark;
        a85d_pkg::t_kind mark_kind;
    } t_run;

    logic        r_a_valid;
    t_item       r_a;
    logic        r_run_valid;
    t_run        r_run;
    logic [1:0]  r_idx;
    logic [31:0] r_gv;
    logic [2:0]  r_dc;
    logic        r_ended;

    logic [31:0] n_gv;
    logic [2:0]  n_dc;
    logic        n_ended;
    t_run        n_run;
    logic        n_load;

    logic [2:0]  run_total;
    logic        out_last;
    logic        out_fire;
    logic        run_free;
    logic        a_move;
    logic        in_fire;
    logic        is_data;
    logic [7:0]  sel_byte;
    logic [7:0]  digit;
    logic [31:0] mul85;
    logic [31:0] horner;
    logic [31:0] pad_prod;
    logic [31:0] flush_word;
    logic [2:0]  flush_n;

    assign run_total = r_run.nbytes + {2'b00, r_run.mark};
    assign out_last  = ({1'b0, r_idx} == (run_total - 3'd1));
    assign out_fire  = r_run_valid && o_res.ready;
    assign run_free  = !r_run_valid || (out_fire && out_last);
    assign a_move    = r_a_valid && run_free;
    assign i_in.ready = !r_a_valid || run_free;
    assign in_fire   = i_in.valid && i_in.ready;

    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = r_run.word[31:24];
            2'd1:    sel_byte = r_run.word[23:16];
            2'd2:    sel_byte = r_run.word[15:8];
            default: sel_byte = r_run.word[7:0];
        endcase
    end

    assign is_data           = ({1'b0, r_idx} < r_run.nbytes);
    assign o_res.valid       = r_run_valid;
    assign o_res.data_byte   = is_data ? sel_byte : 8'd0;
    assign o_res.result_kind = is_data ? a85d_pkg::KIND_DATA : r_run.mark_kind;
    assign o_res.last_of_run = out_last;

    assign digit      = r_a.enc_byte - a85d_pkg::CHAR_FIRST;
    assign mul85      = r_gv * a85d_pkg::BASE;
    assign horner     = mul85 + {24'd0, digit};
    assign pad_prod   = (r_gv + 32'd1) * {12'd0, a85d_pkg::pad_scale(r_dc)};
    assign flush_word = pad_prod - 32'd1;
    assign flush_n    = (r_dc >= 3'd2) ? (r_dc - 3'd1) : 3'd0;

    always_comb begin
        n_gv    = r_gv;
        n_dc    = r_dc;
        n_ended = r_ended;
        n_load  = 1'b0;
        n_run   = '{word: flush_word, nbytes: flush_n, mark: 1'b0,
                    mark_kind: a85d_pkg::KIND_BAD};
        if (r_a.restart) begin
            n_gv    = 32'd0;
            n_dc    = 3'd0;
            n_ended = 1'b0;
        end else if (r_ended) begin
            n_load = 1'b0;
        end else if (r_a.end_of_input || r_a.enc_byte == a85d_pkg::CHAR_TILDE) begin
            n_run.mark      = 1'b1;
            n_run.mark_kind = a85d_pkg::KIND_END;
            n_load          = 1'b1;
            n_gv            = 32'd0;
            n_dc            = 3'd0;
            n_ended         = 1'b1;
        end else if (r_a.enc_byte inside {[a85d_pkg::CHAR_TAB : a85d_pkg::CHAR_CR],
                                          a85d_pkg::CHAR_SPACE}) begin
            n_load = 1'b0;
        end else if (r_a.enc_byte == a85d_pkg::CHAR_Z && r_dc == 3'd0) begin
            n_run.word   = 32'd0;
            n_run.nbytes = a85d_pkg::WORD_BYTES;
            n_load       = 1'b1;
        end else if (r_a.enc_byte inside {[a85d_pkg::CHAR_FIRST : a85d_pkg::CHAR_LAST]}) begin
            if (r_dc == a85d_pkg::LAST_DIGIT) begin
                n_run.word   = horner;
                n_run.nbytes = a85d_pkg::WORD_BYTES;
                n_load       = 1'b1;
                n_gv         = 32'd0;
                n_dc         = 3'd0;
            end else begin
                n_gv = horner;
                n_dc = r_dc + 3'd1;
            end
        end else begin
            n_run.mark      = 1'b1;
            n_run.mark_kind = a85d_pkg::KIND_BAD;
            n_load          = 1'b1;
            n_gv            = 32'd0;
            n_dc            = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_run_valid <= 1'b0;
            r_idx       <= 2'd0;
            r_gv        <= 32'd0;
            r_dc        <= 3'd0;
            r_ended     <= 1'b0;
        end else begin
            if (in_fire) begin
                r_a_valid <= 1'b1;
            end else if (a_move) begin
                r_a_valid <= 1'b0;
            end
            if (a_move) begin
                r_gv    <= n_gv;
                r_dc    <= n_dc;
                r_ended <= n_ended;
            end
            if (a_move && n_load) begin
                r_run_valid <= 1'b1;
                r_idx       <= 2'd0;
            end else if (out_fire) begin
                if (out_last) begin
                    r_run_valid <= 1'b0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a <= '{enc_byte: i_in.enc_byte, end_of_input: i_in.end_of_input,
                     restart: i_in.restart};
        end
        if (a_move && n_load) begin
            r_run <= n_run;
        end
    end

endmodule

// ===== hw/rtl/a85d_checker.sv =====
// Port-level checker for the ASCII85 decoder and its bind to the top level.
module a85d_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_data_byte,
    input logic [1:0] i_result_kind,
    input logic       i_last_of_run
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_data_byte)
            && $stable(i_result_kind) && $stable(i_last_of_run)))
        else $error("stalled result changed");

    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_result_kind != a85d_pkg::KIND_DATA) |-> i_last_of_run)
        else $error("marker not last of its run");

    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_result_kind != a85d_pkg::KIND_DATA) |-> (i_data_byte == 8'd0))
        else $error("marker carries nonzero data");

    a_ready_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> i_in_ready)
        else $error("input not ready after reset");

    a_end_then_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_result_kind == a85d_pkg::KIND_END)
            |=> !i_out_valid)
        else $error("unexpected result after end");

endmodule

bind ascii85_decoder_top a85d_checker u_a85d_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_data_byte   (o_res.data_byte),
    .i_result_kind (o_res.result_kind),
    .i_last_of_run (o_res.last_of_run)
);
